>>> hw/rtl/abf_pkg.sv
// ----------------------------------------------------------------------------
// abf_pkg
// Shared widths, types and register codes of the anharmonic bond force block.
// ----------------------------------------------------------------------------
`default_nettype none

package abf_pkg;

    // Fixed-point format of every data word (Q16.16 in 32 bits).
    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;

    // Derived datapath widths.
    localparam int ROOT_W = DATA_W + 1;        // bond length r
    localparam int RSQ_W  = 2 * DATA_W + 2;    // r squared
    localparam int GMAG_W = DATA_W + 3;        // magnitude of the force numerator
    localparam int QUO_W  = GMAG_W + FRAC_W;   // quotient of numerator over r

    // Stream payload widths.
    localparam int S_TDATA_W = 3 * DATA_W;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 4 * DATA_W;
    localparam int M_TUSER_W = 2;

    localparam int CFG_IDX_W = 4;

    // Magnitude limits of a signed word.
    localparam logic [DATA_W-1:0] MAG_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] MAG_NEG = {1'b1, {(DATA_W-1){1'b0}}};

    // Reset value of the rest lengths: 1.0.
    localparam logic [DATA_W-2:0] REST_RESET = (DATA_W-1)'(1) << FRAC_W;

    // Bond kind code that selects the second coefficient set.
    localparam logic [1:0] KIND_TYPE2 = 2'd2;

    typedef logic signed [DATA_W-1:0] data_t;

    // One rounded product or clipped value with its clip flag.
    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     sat;
    } fx_res_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUAD1    = 4'd0,
        REG_CUBIC1   = 4'd1,
        REG_QUARTIC1 = 4'd2,
        REG_REST1    = 4'd3,
        REG_QUAD2    = 4'd4,
        REG_CUBIC2   = 4'd5,
        REG_QUARTIC2 = 4'd6,
        REG_REST2    = 4'd7
    } cfg_reg_t;

endpackage

`default_nettype wire

>>> hw/rtl/anharmonic_bond_force_top.sv
// ----------------------------------------------------------------------------
// anharmonic_bond_force_top
// Quartic anharmonic bond force and energy, one bond word per cycle unless stalled.
// ----------------------------------------------------------------------------
// Each word on the s_ channel is one bond: the separation of its two atoms
// and a bond kind that picks one of two coefficient sets. Each word on the
// m_ channel is the force on the first atom, the bond energy and two flags.
// Every input word produces exactly one output word, in order.
// The coefficient registers are written on the cfg_ channel, which is always
// ready; they must only change while no bond is in flight.
// The datapath is a fixed pipeline of 98 register stages plus the output
// register. The length is set by the bit-serial square root (33 stages) and
// the divider (51 stages). A new word is accepted in every cycle while the
// skid register is empty.
// When the receiver stalls, the output register holds its word and one more
// finished word parks in a skid register; only then does s_tready drop and
// the whole pipeline freeze, so no word is lost or repeated.
// Reset (aresetn low, synchronous) clears all valid bits and the skid, sets
// every coefficient to 0 and both rest lengths to 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module anharmonic_bond_force_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata: sep_x, sep_y, sep_z.
    input  logic [abf_pkg::S_TDATA_W-1:0]     s_tdata,
    // tuser: bond_kind[1:0], energy_enable.
    input  logic [abf_pkg::S_TUSER_W-1:0]     s_tuser,
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata: force_x, force_y, force_z, bond_energy.
    output logic [abf_pkg::M_TDATA_W-1:0]     m_tdata,
    // tuser: zero_length, saturated.
    output logic [abf_pkg::M_TUSER_W-1:0]     m_tuser,
    // Configuration writes.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [abf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [abf_pkg::DATA_W-1:0]        cfg_wdata
);
    import abf_pkg::*;

    // Stage numbers: the register stage at which each value becomes valid.
    localparam int T_IN  = 1;
    localparam int T_SQ  = T_IN + 1;
    localparam int T_RSQ = T_SQ + 1;
    localparam int T_R   = T_RSQ + ROOT_W;
    localparam int T_DR  = T_R + 1;
    localparam int T_DR2 = T_DR + 2;
    localparam int T_DR3 = T_DR2 + 2;
    localparam int T_DR4 = T_DR3 + 2;
    localparam int T_E4  = T_DR4 + 2;
    localparam int T_G   = T_DR4 + 1;
    localparam int T_E   = T_E4 + 1;
    localparam int T_Q   = T_G + QUO_W;
    localparam int T_S   = T_Q + 1;
    localparam int T_F   = T_S + 2;

    localparam int FXW = $bits(fx_res_t);

    // ------------------------------------------------------------------
    // Coefficient registers.
    // ------------------------------------------------------------------
    data_t             quad1_reg, quad1_next, cubic1_reg, cubic1_next;
    data_t             quart1_reg, quart1_next, quad2_reg, quad2_next;
    data_t             cubic2_reg, cubic2_next, quart2_reg, quart2_next;
    logic [DATA_W-2:0] rest1_reg, rest1_next, rest2_reg, rest2_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        quad1_next  = quad1_reg;
        cubic1_next = cubic1_reg;
        quart1_next = quart1_reg;
        rest1_next  = rest1_reg;
        quad2_next  = quad2_reg;
        cubic2_next = cubic2_reg;
        quart2_next = quart2_reg;
        rest2_next  = rest2_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_QUAD1:    quad1_next  = cfg_wdata;
                REG_CUBIC1:   cubic1_next = cfg_wdata;
                REG_QUARTIC1: quart1_next = cfg_wdata;
                REG_REST1:    rest1_next  = cfg_wdata[DATA_W-2:0];
                REG_QUAD2:    quad2_next  = cfg_wdata;
                REG_CUBIC2:   cubic2_next = cfg_wdata;
                REG_QUARTIC2: quart2_next = cfg_wdata;
                REG_REST2:    rest2_next  = cfg_wdata[DATA_W-2:0];
                default: begin
                    // Indexes past the register list are dropped.
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quad1_reg  <= '0;
            cubic1_reg <= '0;
            quart1_reg <= '0;
            rest1_reg  <= REST_RESET;
            quad2_reg  <= '0;
            cubic2_reg <= '0;
            quart2_reg <= '0;
            rest2_reg  <= REST_RESET;
        end else begin
            quad1_reg  <= quad1_next;
            cubic1_reg <= cubic1_next;
            quart1_reg <= quart1_next;
            rest1_reg  <= rest1_next;
            quad2_reg  <= quad2_next;
            cubic2_reg <= cubic2_next;
            quart2_reg <= quart2_next;
            rest2_reg  <= rest2_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline enable and valid bits. The pipeline only stops when the
    // skid register is occupied.
    // ------------------------------------------------------------------
    logic             ce;
    logic             skid_vld_reg;
    logic [T_F-1:0]   vld_reg;

    assign ce       = ~skid_vld_reg;
    assign s_tready = ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[T_F-2:0], s_tvalid};
        end
    end

    // Saturating clip of a sum that carries two guard bits.
    function automatic fx_res_t clip_w(input logic [DATA_W+1:0] v);
        fx_res_t r;
        r.sat = (v[DATA_W+1:DATA_W-1] != 3'b000) && (v[DATA_W+1:DATA_W-1] != 3'b111);
        if (!r.sat) begin
            r.val = data_t'(v[DATA_W-1:0]);
        end else if (v[DATA_W+1]) begin
            r.val = data_t'(MAG_NEG);
        end else begin
            r.val = data_t'(MAG_POS);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input register, squares and their sum.
    // ------------------------------------------------------------------
    data_t                 d_reg [3];
    logic                  t2_reg, en_reg;
    logic [2*DATA_W-1:0]   sq_reg [3], sq_next [3];
    logic [DATA_W-1:0]     dmag [3];
    logic [RSQ_W-1:0]      rsq_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dmag[i]    = d_reg[i][DATA_W-1] ? DATA_W'(~d_reg[i] + 1'b1) : DATA_W'(d_reg[i]);
            sq_next[i] = (2*DATA_W)'(dmag[i]) * (2*DATA_W)'(dmag[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                d_reg[i]  <= data_t'(s_tdata[i*DATA_W +: DATA_W]);
                sq_reg[i] <= sq_next[i];
            end
            t2_reg  <= (s_tuser[1:0] == KIND_TYPE2);
            en_reg  <= s_tuser[2];
            rsq_reg <= RSQ_W'(sq_reg[0]) + RSQ_W'(sq_reg[1]) + RSQ_W'(sq_reg[2]);
        end
    end

    // ------------------------------------------------------------------
    // Bond length and its deviation from the rest length.
    // ------------------------------------------------------------------
    logic [ROOT_W-1:0] root, root_dr_reg, root_g;
    logic              t2_r, t2_dr2, t2_dr3, t2_dr4;
    logic [DATA_W+1:0] diff;
    fx_res_t           dr_reg, dr_next;
    logic              zero_reg;

    abf_sqrt u_sqrt (.aclk(aclk), .ce(ce), .rsq(rsq_reg), .root(root));

    abf_delay #(.WIDTH(1), .DEPTH(T_R - T_IN)) u_dl_t2r (
        .aclk(aclk), .ce(ce), .din(t2_reg), .dout(t2_r));
    abf_delay #(.WIDTH(1), .DEPTH(T_DR2 - T_R)) u_dl_t2dr2 (
        .aclk(aclk), .ce(ce), .din(t2_r), .dout(t2_dr2));
    abf_delay #(.WIDTH(1), .DEPTH(T_DR3 - T_DR2)) u_dl_t2dr3 (
        .aclk(aclk), .ce(ce), .din(t2_dr2), .dout(t2_dr3));
    abf_delay #(.WIDTH(1), .DEPTH(T_DR4 - T_DR3)) u_dl_t2dr4 (
        .aclk(aclk), .ce(ce), .din(t2_dr3), .dout(t2_dr4));

    always_comb begin
        diff    = (DATA_W+2)'(root) - (DATA_W+2)'(t2_r ? rest2_reg : rest1_reg);
        dr_next = clip_w(diff);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dr_reg      <= dr_next;
            zero_reg    <= (root == '0);
            root_dr_reg <= root;
        end
    end

    // ------------------------------------------------------------------
    // Powers of dr and the coefficient products.
    // ------------------------------------------------------------------
    data_t   dr_t39, dr_t41;
    fx_res_t dr2, dr3, dr4, kdr, kdr2, kkdr2, kkdr3, kkkdr3, kkkdr4;

    abf_delay #(.WIDTH(DATA_W), .DEPTH(T_DR2 - T_DR)) u_dl_dr39 (
        .aclk(aclk), .ce(ce), .din(dr_reg.val), .dout(dr_t39));
    abf_delay #(.WIDTH(DATA_W), .DEPTH(T_DR3 - T_DR2)) u_dl_dr41 (
        .aclk(aclk), .ce(ce), .din(dr_t39), .dout(dr_t41));

    abf_fmul u_dr2 (.aclk(aclk), .ce(ce), .a(dr_reg.val), .b(dr_reg.val), .res(dr2));

    abf_fmul u_dr3 (.aclk(aclk), .ce(ce), .a(dr2.val), .b(dr_t39), .res(dr3));
    abf_fmul u_kdr (.aclk(aclk), .ce(ce), .a(t2_dr2 ? quad2_reg : quad1_reg),
        .b(dr_t39), .res(kdr));
    abf_fmul u_kdr2 (.aclk(aclk), .ce(ce), .a(t2_dr2 ? quad2_reg : quad1_reg),
        .b(dr2.val), .res(kdr2));
    abf_fmul u_kkdr2 (.aclk(aclk), .ce(ce), .a(t2_dr2 ? cubic2_reg : cubic1_reg),
        .b(dr2.val), .res(kkdr2));

    abf_fmul u_dr4 (.aclk(aclk), .ce(ce), .a(dr3.val), .b(dr_t41), .res(dr4));
    abf_fmul u_kkdr3 (.aclk(aclk), .ce(ce), .a(t2_dr3 ? cubic2_reg : cubic1_reg),
        .b(dr3.val), .res(kkdr3));
    abf_fmul u_kkkdr3 (.aclk(aclk), .ce(ce), .a(t2_dr3 ? quart2_reg : quart1_reg),
        .b(dr3.val), .res(kkkdr3));

    abf_fmul u_kkkdr4 (.aclk(aclk), .ce(ce), .a(t2_dr4 ? quart2_reg : quart1_reg),
        .b(dr4.val), .res(kkkdr4));

    // Clip flags that count for every bond: dr, dr^2 and dr^3.
    logic sat_dr_t41, sat_dr2_t41, base_t41, base_f;

    abf_delay #(.WIDTH(1), .DEPTH(T_DR3 - T_DR)) u_dl_sdr (
        .aclk(aclk), .ce(ce), .din(dr_reg.sat), .dout(sat_dr_t41));
    abf_delay #(.WIDTH(1), .DEPTH(T_DR3 - T_DR2)) u_dl_sdr2 (
        .aclk(aclk), .ce(ce), .din(dr2.sat), .dout(sat_dr2_t41));

    assign base_t41 = sat_dr_t41 | sat_dr2_t41 | dr3.sat;

    abf_delay #(.WIDTH(1), .DEPTH(T_F - T_DR3)) u_dl_base (
        .aclk(aclk), .ce(ce), .din(base_t41), .dout(base_f));

    // ------------------------------------------------------------------
    // Force numerator g = 2*k*dr + 3*kk*dr^2 + 4*kkk*dr^3.
    // ------------------------------------------------------------------
    fx_res_t                kdr_g, kkdr2_g;
    logic signed [DATA_W+3:0] g;
    logic [GMAG_W-1:0]      gmag_reg;
    logic                   gpos_reg, gsat_reg, gpos_q, gsat_f;

    abf_delay #(.WIDTH(2 * FXW), .DEPTH(T_G - 1 - T_DR3)) u_dl_g (
        .aclk(aclk), .ce(ce), .din({kdr, kkdr2}), .dout({kdr_g, kkdr2_g}));

    always_comb begin
        g = ((DATA_W+4)'(kdr_g.val) <<< 1) + (DATA_W+4)'(kkdr2_g.val)
            + ((DATA_W+4)'(kkdr2_g.val) <<< 1) + ((DATA_W+4)'(kkkdr3.val) <<< 2);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            gmag_reg <= g[DATA_W+3] ? GMAG_W'(-g) : GMAG_W'(g);
            gpos_reg <= !g[DATA_W+3] && (g != '0);
            gsat_reg <= kdr_g.sat | kkdr2_g.sat | kkkdr3.sat;
        end
    end

    // ------------------------------------------------------------------
    // Energy k*dr^2 + kk*dr^3 + kkk*dr^4, with its own clip flag.
    // ------------------------------------------------------------------
    fx_res_t           kdr2_e, kkdr3_e, esum, e_reg, e_f;
    logic              dr4sat_e, esat_reg, esat_f;
    logic [DATA_W+1:0] e_wide;

    abf_delay #(.WIDTH(FXW), .DEPTH(T_E4 - T_DR3)) u_dl_e2 (
        .aclk(aclk), .ce(ce), .din(kdr2), .dout(kdr2_e));
    abf_delay #(.WIDTH(FXW + 1), .DEPTH(T_E4 - T_DR4)) u_dl_e3 (
        .aclk(aclk), .ce(ce), .din({kkdr3, dr4.sat}), .dout({kkdr3_e, dr4sat_e}));

    always_comb begin
        e_wide = (DATA_W+2)'(kdr2_e.val) + (DATA_W+2)'(kkdr3_e.val)
            + (DATA_W+2)'(kkkdr4.val);
        esum   = clip_w(e_wide);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            e_reg    <= esum;
            esat_reg <= esum.sat | kdr2_e.sat | kkdr3_e.sat | dr4sat_e | kkkdr4.sat;
        end
    end

    abf_delay #(.WIDTH(FXW + 1), .DEPTH(T_F - T_E)) u_dl_ef (
        .aclk(aclk), .ce(ce), .din({e_reg, esat_reg}), .dout({e_f, esat_f}));

    // ------------------------------------------------------------------
    // Scalar s = -g / r and the force vector s * sep.
    // ------------------------------------------------------------------
    logic [QUO_W-1:0]  quo;
    logic [DATA_W-1:0] slim, smag;
    logic              ssat;
    fx_res_t           s_reg, s_next;
    logic              ssat_f;
    data_t             d_s [3];
    fx_res_t           frc [3];

    abf_delay #(.WIDTH(ROOT_W), .DEPTH(T_G - T_DR)) u_dl_root (
        .aclk(aclk), .ce(ce), .din(root_dr_reg), .dout(root_g));
    abf_delay #(.WIDTH(1), .DEPTH(T_Q - T_G)) u_dl_gpos (
        .aclk(aclk), .ce(ce), .din(gpos_reg), .dout(gpos_q));
    abf_delay #(.WIDTH(1), .DEPTH(T_F - T_G)) u_dl_gsat (
        .aclk(aclk), .ce(ce), .din(gsat_reg), .dout(gsat_f));

    abf_div u_div (.aclk(aclk), .ce(ce), .num(gmag_reg), .den(root_g), .quo(quo));

    // A positive numerator gives a negative scalar.
    always_comb begin
        slim       = gpos_q ? MAG_NEG : MAG_POS;
        ssat       = quo > QUO_W'(slim);
        smag       = ssat ? slim : quo[DATA_W-1:0];
        s_next.val = gpos_q ? data_t'(~smag + 1'b1) : data_t'(smag);
        s_next.sat = ssat;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s_reg <= s_next;
        end
    end

    abf_delay #(.WIDTH(1), .DEPTH(T_F - T_S)) u_dl_ssat (
        .aclk(aclk), .ce(ce), .din(s_reg.sat), .dout(ssat_f));
    abf_delay #(.WIDTH(S_TDATA_W), .DEPTH(T_S - T_IN)) u_dl_sep (
        .aclk(aclk), .ce(ce), .din({d_reg[2], d_reg[1], d_reg[0]}),
        .dout({d_s[2], d_s[1], d_s[0]}));

    for (genvar i = 0; i < 3; i++) begin : g_force
        abf_fmul u_force (.aclk(aclk), .ce(ce), .a(s_reg.val), .b(d_s[i]), .res(frc[i]));
    end

    // ------------------------------------------------------------------
    // Result assembly.
    // ------------------------------------------------------------------
    logic                 zero_f, en_f, res_sat;
    logic [M_TDATA_W-1:0] res_data;
    logic [M_TUSER_W-1:0] res_user;

    abf_delay #(.WIDTH(1), .DEPTH(T_F - T_DR)) u_dl_zero (
        .aclk(aclk), .ce(ce), .din(zero_reg), .dout(zero_f));
    abf_delay #(.WIDTH(1), .DEPTH(T_F - T_IN)) u_dl_en (
        .aclk(aclk), .ce(ce), .din(en_reg), .dout(en_f));

    always_comb begin
        res_data = {(en_f ? e_f.val : data_t'(0)),
                    (zero_f ? data_t'(0) : frc[2].val),
                    (zero_f ? data_t'(0) : frc[1].val),
                    (zero_f ? data_t'(0) : frc[0].val)};
        // Force-path clips count only when a force was formed, energy-path
        // clips only when the energy was asked for.
        res_sat  = base_f
                 | (!zero_f & (gsat_f | ssat_f | frc[0].sat | frc[1].sat | frc[2].sat))
                 | (en_f & esat_f);
        res_user = {res_sat, zero_f};
    end

    // ------------------------------------------------------------------
    // Output register with one skid entry.
    // ------------------------------------------------------------------
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, skid_data_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg, skid_user_reg;
    logic                 out_free, tail_vld;

    assign out_free = !m_tvalid_reg || m_tready;
    assign tail_vld = vld_reg[T_F-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (out_free) begin
                m_tvalid_reg <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
        end else if (tail_vld) begin
            if (out_free) begin
                m_tvalid_reg <= 1'b1;
            end else begin
                skid_vld_reg <= 1'b1;
            end
        end else if (out_free) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (out_free) begin
                m_tdata_reg <= skid_data_reg;
                m_tuser_reg <= skid_user_reg;
            end
        end else if (tail_vld) begin
            if (out_free) begin
                m_tdata_reg <= res_data;
                m_tuser_reg <= res_user;
            end else begin
                skid_data_reg <= res_data;
                skid_user_reg <= res_user;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

>>> hw/rtl/abf_delay.sv
// ----------------------------------------------------------------------------
// abf_delay
// Fixed-length delay line that moves with the pipeline enable.
// ----------------------------------------------------------------------------
`default_nettype none

module abf_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             aclk,
    input  logic             ce,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] pipe_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (ce) begin
            pipe_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign dout = pipe_reg[DEPTH-1];

endmodule

`default_nettype wire

>>> hw/rtl/abf_fmul.sv
// ----------------------------------------------------------------------------
// abf_fmul
// Two-stage fixed-point multiplier: exact product, then round half away
// from zero and clip to a signed word.
// ----------------------------------------------------------------------------
`default_nettype none

module abf_fmul (
    input  logic            aclk,
    input  logic            ce,
    input  abf_pkg::data_t  a,
    input  abf_pkg::data_t  b,
    output abf_pkg::fx_res_t res
);
    import abf_pkg::*;

    localparam int PW = 2 * DATA_W;
    localparam int TW = PW + 1 - FRAC_W;
    localparam logic [PW:0] HALF = (PW+1)'(1) << (FRAC_W - 1);

    logic [PW-1:0]     prod_reg, prod_next;
    logic              neg_reg, neg_next;
    fx_res_t           res_reg, res_next;
    logic [DATA_W-1:0] am, bm, lim, m;
    logic [PW:0]       rnd;
    logic [TW-1:0]     t;
    logic              sat;

    always_comb begin
        am = a[DATA_W-1] ? DATA_W'(~a + 1'b1) : DATA_W'(a);
        bm = b[DATA_W-1] ? DATA_W'(~b + 1'b1) : DATA_W'(b);
        prod_next = PW'(am) * PW'(bm);
        neg_next  = a[DATA_W-1] ^ b[DATA_W-1];
    end

    always_comb begin
        rnd = (PW+1)'(prod_reg) + HALF;
        t   = rnd[PW:FRAC_W];
        lim = neg_reg ? MAG_NEG : MAG_POS;
        sat = t > TW'(lim);
        m   = sat ? lim : t[DATA_W-1:0];
        res_next.val = neg_reg ? data_t'(~m + 1'b1) : data_t'(m);
        res_next.sat = sat;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            prod_reg <= prod_next;
            neg_reg  <= neg_next;
            res_reg  <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

>>> hw/rtl/abf_sqrt.sv
// ----------------------------------------------------------------------------
// abf_sqrt
// Pipelined integer square root, one result bit per stage, floor rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module abf_sqrt (
    input  logic                         aclk,
    input  logic                         ce,
    input  logic [abf_pkg::RSQ_W-1:0]    rsq,
    output logic [abf_pkg::ROOT_W-1:0]   root
);
    import abf_pkg::*;

    logic [RSQ_W-1:0]  rem_reg [ROOT_W];
    logic [ROOT_W-1:0] res_reg [ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++) begin : g_bit
        localparam int B = ROOT_W - 1 - i;

        logic [RSQ_W-1:0]  rem_in, trial, rem_next;
        logic [ROOT_W-1:0] res_in, res_next;
        logic              take;

        if (i == 0) begin : g_first
            assign rem_in = rsq;
            assign res_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign res_in = res_reg[i-1];
        end

        // The remainder holds rsq minus res squared; setting bit B adds
        // res * 2^(B+1) + 2^(2B) to the square.
        always_comb begin
            trial    = (RSQ_W'(res_in) << (B + 1)) + (RSQ_W'(1) << (2 * B));
            take     = rem_in >= trial;
            rem_next = take ? rem_in - trial : rem_in;
            res_next = take ? (res_in | (ROOT_W'(1) << B)) : res_in;
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[i] <= rem_next;
                res_reg[i] <= res_next;
            end
        end
    end

    assign root = res_reg[ROOT_W-1];

endmodule

`default_nettype wire

>>> hw/rtl/abf_div.sv
// ----------------------------------------------------------------------------
// abf_div
// Pipelined restoring divider, one quotient bit per stage. The dividend is
// the numerator magnitude scaled up by the fraction bits.
// ----------------------------------------------------------------------------
`default_nettype none

module abf_div (
    input  logic                         aclk,
    input  logic                         ce,
    input  logic [abf_pkg::GMAG_W-1:0]   num,
    input  logic [abf_pkg::ROOT_W-1:0]   den,
    output logic [abf_pkg::QUO_W-1:0]    quo
);
    import abf_pkg::*;

    logic [ROOT_W-1:0] rem_reg [QUO_W];
    logic [QUO_W-1:0]  n_reg   [QUO_W];
    logic [QUO_W-1:0]  q_reg   [QUO_W];
    logic [ROOT_W-1:0] d_reg   [QUO_W];

    for (genvar i = 0; i < QUO_W; i++) begin : g_bit
        localparam int P = QUO_W - 1 - i;

        logic [ROOT_W-1:0] rem_in, d_in, rem_next;
        logic [QUO_W-1:0]  n_in, q_in, q_next;
        logic [ROOT_W:0]   trial;
        logic              take;

        if (i == 0) begin : g_first
            assign rem_in = '0;
            assign n_in   = {num, FRAC_W'(0)};
            assign q_in   = '0;
            assign d_in   = den;
        end else begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign n_in   = n_reg[i-1];
            assign q_in   = q_reg[i-1];
            assign d_in   = d_reg[i-1];
        end

        always_comb begin
            trial    = {rem_in, n_in[P]};
            take     = trial >= {1'b0, d_in};
            rem_next = take ? ROOT_W'(trial - {1'b0, d_in}) : trial[ROOT_W-1:0];
            q_next   = take ? (q_in | (QUO_W'(1) << P)) : q_in;
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[i] <= rem_next;
                n_reg[i]   <= n_in;
                q_reg[i]   <= q_next;
                d_reg[i]   <= d_in;
            end
        end
    end

    assign quo = q_reg[QUO_W-1];

endmodule

`default_nettype wire

>>> hw/rtl/abf_checker.sv
// ----------------------------------------------------------------------------
// abf_checker
// Port-level checks of the anharmonic bond force block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module abf_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [abf_pkg::S_TDATA_W-1:0]     s_tdata,
    input logic [abf_pkg::S_TUSER_W-1:0]     s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [abf_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic [abf_pkg::M_TUSER_W-1:0]     m_tuser,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [abf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input logic [abf_pkg::DATA_W-1:0]        cfg_wdata
);
    import abf_pkg::*;

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // A zero-length bond carries no force.
    a_zero_force: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[3*DATA_W-1:0] == '0)
        else $error("zero-length bond with nonzero force");

    // The input side only backs up after the output stalled.
    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without an output stall");

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind anharmonic_bond_force_top abf_checker u_abf_checker (.*);

`default_nettype wire
